// File: design/pssl_pkg.sv
// Shared constants, register codes and controller/datapath interface types
// for the per-source sliding window limiter. No dependencies.
package pssl_pkg;

   localparam int SOURCE_SLOTS_DEF = 64;
   localparam int LOG_DEPTH_DEF    = 32;

   localparam int SLOT_IN_W  = 6;
   localparam int TIME_W     = 32;
   localparam int WINDOW_W   = 16;
   localparam int HITS_W     = 6;
   localparam int SLOT_CMP_W = 11;

   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 8;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;

   localparam logic [WINDOW_W-1:0] WINDOW_RESET   = 16'd60;
   localparam logic [HITS_W-1:0]   MAX_HITS_RESET = 6'd30;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WINDOW   = 1'b0,
      CSR_MAX_HITS = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic clear;
      logic lookup;
      logic load;
      logic pop;
      logic decide;
      logic push;
   } pssl_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic in_range;
      logic scan_pop;
      logic rsp_free;
   } pssl_status_type;

endpackage

// File: design/per_source_sliding_window_limiter.sv
// Per-source sliding window rate limiter. After reset a clearing pass
// empties the per-source logs; req_tready stays low meanwhile, CSR writes
// are taken. A request is looked up, its head and count are loaded, expired
// log entries (up to LOG_DEPTH) are dropped one per cycle through the time
// log RAM read port, and the verdict is decided and pushed into the result
// register once it is free; the next request can be taken as the result is
// presented. One request is in work at a time; a registered result may wait
// for rsp_tready while the next request is taken. Slots at or above
// SOURCE_SLOTS are refused without touching the per-source logs, their
// refusal pushed into the result register once it is free.
module per_source_sliding_window_limiter #(
   parameter int SOURCE_SLOTS = pssl_pkg::SOURCE_SLOTS_DEF,
   parameter int LOG_DEPTH    = pssl_pkg::LOG_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [pssl_pkg::REQ_DATA_W-1:0]  req_tdata,   // source_slot, now_seconds
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [pssl_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // allowed
   input  logic                             csr_we,
   input  logic [pssl_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pssl_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import pssl_pkg::*;

   pssl_cmd_type    cmd;
   pssl_status_type status;

   pssl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pssl_dp #(
      .SOURCE_SLOTS (SOURCE_SLOTS),
      .LOG_DEPTH    (LOG_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

// File: design/pssl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pssl_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] ram_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= ram_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/pssl_ctrl.sv
// Sequencing controller of the limiter: clearing pass, lookup, log scan,
// decision and result hand-off. Depends on pssl_pkg.
module pssl_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  pssl_pkg::pssl_status_type status,
   output pssl_pkg::pssl_cmd_type    cmd
);
   import pssl_pkg::*;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_LOAD,
      S_SCAN,
      S_DECIDE,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      ready_in = ready_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_done) begin
               state_in = S_IDLE;
               ready_in = 1'b1;
            end
         end
         S_IDLE: begin
            if (req_tvalid && ready_ff) begin
               cmd.lookup = 1'b1;
               ready_in   = 1'b0;
               state_in   = status.in_range ? S_LOAD : S_FINISH;
            end
         end
         S_LOAD: begin
            cmd.load = 1'b1;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (status.scan_pop) begin
               cmd.pop = 1'b1;
            end else begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            if (status.rsp_free) begin
               cmd.push = 1'b1;
               state_in = S_IDLE;
               ready_in = 1'b1;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (status.rsp_free) begin
               cmd.push = 1'b1;
               state_in = S_IDLE;
               ready_in = 1'b1;
            end
         end
      endcase
   end

   assign req_tready = ready_ff;

endmodule

// File: design/pssl_dp.sv
// Datapath of the limiter: per-source head/count table, time log RAM,
// age compare, limit check, config registers and result register.
// Depends on pssl_pkg and pssl_ram.
module pssl_dp #(
   parameter int SOURCE_SLOTS = pssl_pkg::SOURCE_SLOTS_DEF,
   parameter int LOG_DEPTH    = pssl_pkg::LOG_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [pssl_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [pssl_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                               csr_we,
   input  logic [pssl_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [pssl_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  pssl_pkg::pssl_cmd_type             cmd,
   output pssl_pkg::pssl_status_type          status
);
   import pssl_pkg::*;

   localparam int SLOT_W    = (SOURCE_SLOTS > 1) ? $clog2(SOURCE_SLOTS) : 1;
   localparam int PTR_W     = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
   localparam int CNT_W     = $clog2(LOG_DEPTH + 1);
   localparam int SUM_W     = CNT_W + 1;
   localparam int META_W    = PTR_W + CNT_W;
   localparam int HIT_AW    = SLOT_W + PTR_W;
   localparam int HIT_DEPTH = SOURCE_SLOTS * (2 ** PTR_W);
   localparam int LIM_W     = 8;

   logic [SLOT_IN_W-1:0]  req_slot;
   logic [TIME_W-1:0]     req_now;
   logic [SLOT_CMP_W-1:0] req_slot_wide;
   logic [SLOT_W-1:0]     req_idx;

   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [TIME_W-1:0]   now_ff, now_in;
   logic [PTR_W-1:0]    head_ff, head_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                allowed_ff, allowed_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_allowed_ff, rsp_allowed_in;
   logic [WINDOW_W-1:0] window_ff, window_in;
   logic [HITS_W-1:0]   max_hits_ff, max_hits_in;
   logic [SLOT_W-1:0]   clear_idx_ff, clear_idx_in;

   logic [META_W-1:0] meta_rd, meta_wr_data;
   logic [SLOT_W-1:0] meta_wr_addr;
   logic              meta_wr_en;
   logic [PTR_W-1:0]  meta_head;
   logic [CNT_W-1:0]  meta_count;
   logic [TIME_W-1:0] hit_rd;

   logic [PTR_W-1:0]  head_inc;
   logic [SUM_W-1:0]  tail_sum, tail_wrap;
   logic [PTR_W-1:0]  tail;
   logic [LIM_W-1:0]  limit;
   logic              allow_now;
   logic [CNT_W-1:0]  count_inc;
   logic [TIME_W:0]   age;
   logic              drop;

   assign req_slot      = req_tdata[SLOT_IN_W-1:0];
   assign req_now       = req_tdata[SLOT_IN_W +: TIME_W];
   assign req_slot_wide = SLOT_CMP_W'(req_slot);
   assign req_idx       = req_slot_wide[SLOT_W-1:0];

   assign meta_head  = meta_rd[META_W-1:CNT_W];
   assign meta_count = meta_rd[CNT_W-1:0];

   assign head_inc  = (head_ff == PTR_W'(LOG_DEPTH - 1)) ? '0 : head_ff + PTR_W'(1);
   assign tail_sum  = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign tail_wrap = (tail_sum >= SUM_W'(LOG_DEPTH)) ? tail_sum - SUM_W'(LOG_DEPTH)
                                                      : tail_sum;
   assign tail      = tail_wrap[PTR_W-1:0];
   assign limit     = (LIM_W'(max_hits_ff) > LIM_W'(LOG_DEPTH)) ? LIM_W'(LOG_DEPTH)
                                                                : LIM_W'(max_hits_ff);
   assign allow_now = LIM_W'(count_ff) < limit;
   assign count_inc = count_ff + CNT_W'(1);

   // signed age: a logged time later than now never expires
   assign age  = {1'b0, now_ff} - {1'b0, hit_rd};
   assign drop = !age[TIME_W] && (age[TIME_W-1:0] > TIME_W'(window_ff));

   assign status.clear_done = (clear_idx_ff == SLOT_W'(SOURCE_SLOTS - 1));
   assign status.in_range   = (req_slot_wide < SLOT_CMP_W'(SOURCE_SLOTS));
   assign status.scan_pop   = (count_ff != '0) && drop;
   assign status.rsp_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      slot_in        = slot_ff;
      now_in         = now_ff;
      head_in        = head_ff;
      count_in       = count_ff;
      allowed_in     = allowed_ff;
      clear_idx_in   = clear_idx_ff;
      window_in      = window_ff;
      max_hits_in    = max_hits_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_allowed_in = rsp_allowed_ff;

      if (cmd.clear) begin
         clear_idx_in = clear_idx_ff + SLOT_W'(1);
      end
      if (cmd.lookup) begin
         slot_in    = req_idx;
         now_in     = req_now;
         allowed_in = 1'b0;
      end
      if (cmd.load) begin
         head_in  = meta_head;
         count_in = meta_count;
      end
      if (cmd.pop) begin
         head_in  = head_inc;
         count_in = count_ff - CNT_W'(1);
      end
      if (cmd.decide) begin
         allowed_in = allow_now;
         if (allow_now) begin
            count_in = count_inc;
         end
      end
      if (cmd.push) begin
         rsp_valid_in   = 1'b1;
         rsp_allowed_in = cmd.decide ? allow_now : allowed_ff;
      end
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_WINDOW:   window_in   = csr_wdata[WINDOW_W-1:0];
            CSR_MAX_HITS: max_hits_in = csr_wdata[HITS_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         clear_idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
         window_ff    <= WINDOW_RESET;
         max_hits_ff  <= MAX_HITS_RESET;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         clear_idx_ff <= clear_idx_in;
         rsp_valid_ff <= rsp_valid_in;
         window_ff    <= window_in;
         max_hits_ff  <= max_hits_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff        <= slot_in;
      now_ff         <= now_in;
      allowed_ff     <= allowed_in;
      rsp_allowed_ff <= rsp_allowed_in;
   end

   assign meta_wr_en   = cmd.clear || cmd.decide;
   assign meta_wr_addr = cmd.clear ? clear_idx_ff : slot_ff;
   assign meta_wr_data = cmd.clear ? '0 : {head_ff, (allow_now ? count_inc : count_ff)};

   pssl_ram #(
      .WIDTH  (META_W),
      .DEPTH  (SOURCE_SLOTS),
      .ADDR_W (SLOT_W)
   ) u_meta_ram (
      .clock   (clock),
      .wr_en   (meta_wr_en),
      .wr_addr (meta_wr_addr),
      .wr_data (meta_wr_data),
      .rd_addr (req_idx),
      .rd_data (meta_rd)
   );

   // read address follows the next head so the oldest entry is always ready
   pssl_ram #(
      .WIDTH  (TIME_W),
      .DEPTH  (HIT_DEPTH),
      .ADDR_W (HIT_AW)
   ) u_hit_ram (
      .clock   (clock),
      .wr_en   (cmd.decide && allow_now),
      .wr_addr ({slot_ff, tail}),
      .wr_data (now_ff),
      .rd_addr ({slot_ff, head_in}),
      .rd_data (hit_rd)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_allowed_ff);

`ifndef SYNTHESIS
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> count_ff != '0)
      else $error("log pop with empty log");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      LIM_W'(count_ff) <= LIM_W'(LOG_DEPTH))
      else $error("log count above depth");

   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      SUM_W'(head_ff) < SUM_W'(LOG_DEPTH))
      else $error("log head out of range");

   a_push_free: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwritten before transfer");
`endif

endmodule

// File: sim/tb_per_source_sliding_window_limiter.sv
// Self-checking testbench for per_source_sliding_window_limiter: predicts the
// allow/refuse verdict of each request with its own per-source time logs.
// Depends on pssl_pkg and the limiter RTL only.
module tb_per_source_sliding_window_limiter;
   import pssl_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SLOTS       = SOURCE_SLOTS_DEF;
   localparam int DEPTH       = LOG_DEPTH_DEF;

   class limiter_board;
      logic [TIME_W-1:0]   stamp [SLOTS][DEPTH];
      int unsigned         head [SLOTS];
      int unsigned         fill [SLOTS];
      logic [WINDOW_W-1:0] window;
      logic [HITS_W-1:0]   max_hits;
      bit                  verdicts_due[$];
      int                  mismatches;
      int                  granted;
      int                  denied;

      function new();
         foreach (head[s]) begin
            head[s] = 0;
            fill[s] = 0;
         end
         window   = WINDOW_RESET;
         max_hits = MAX_HITS_RESET;
      endfunction

      function void set_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_WINDOW:   window = value;
            CSR_MAX_HITS: max_hits = value[HITS_W-1:0];
         endcase
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= 10)
            $display("[%0t] %s", $time, msg);
      endfunction

      function void queue_verdict(bit v);
         verdicts_due.insert(verdicts_due.size(), v);
      endfunction

      // predict the verdict of one accepted request transfer
      function void note_request(logic [SLOT_IN_W-1:0] slot, logic [TIME_W-1:0] now);
         int unsigned h;
         int unsigned n;
         int unsigned cap;
         longint      age;
         if (slot >= SLOTS) begin
            queue_verdict(1'b0);
            return;
         end
         h = head[slot] % DEPTH;
         n = (fill[slot] > DEPTH) ? DEPTH : fill[slot];
         while (n > 0) begin
            age = longint'({32'b0, now}) - longint'({32'b0, stamp[slot][h]});
            if (age <= longint'({48'b0, window}))
               break;
            h = (h + 1) % DEPTH;
            n--;
         end
         cap = (max_hits > DEPTH) ? DEPTH : max_hits;
         if (n >= cap) begin
            queue_verdict(1'b0);
         end else begin
            stamp[slot][(h + n) % DEPTH] = now;
            n++;
            queue_verdict(1'b1);
         end
         head[slot] = h;
         fill[slot] = n;
      endfunction

      function void check_verdict(logic allowed);
         bit want;
         if (allowed === 1'b1)
            granted++;
         else
            denied++;
         if (verdicts_due.size() == 0) begin
            flag($sformatf("unexpected result transfer, allowed %0b", allowed));
            return;
         end
         want = verdicts_due[0];
         verdicts_due.delete(0);
         if (allowed !== want)
            flag($sformatf("allowed mismatch: expected %0b got %0b", want, allowed));
      endfunction

      function void finish_check();
         if (verdicts_due.size() != 0)
            flag($sformatf("%0d results never arrived", verdicts_due.size()));
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   csr_index_type         csr_index = CSR_WINDOW;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   limiter_board board = new();
   bit           calm = 1'b0;
   int           sink_hold = 0;
   int           cycle_count = 0;
   int           sent = 0;
   int           settings = 0;

   per_source_sliding_window_limiter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // source_slot, now_seconds
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // allowed
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // result side backpressure in random bursts
   always @(negedge clock) begin
      if (sink_hold > 0) begin
         rsp_tready = 1'b0;
         sink_hold--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         rsp_tready = 1'b0;
         sink_hold = $urandom_range(0, 3);
      end else begin
         rsp_tready = 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            board.note_request(req_tdata[SLOT_IN_W-1:0], req_tdata[SLOT_IN_W +: TIME_W]);
         if (rsp_tvalid && rsp_tready)
            board.check_verdict(rsp_tdata[0]);
      end
   end

   task automatic send_request(input logic [SLOT_IN_W-1:0] slot, input logic [TIME_W-1:0] now);
      int gap;
      gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = {2'b00, now, slot};
      do @(posedge clock); while (!req_tready);
      sent++;
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      board.set_reg(idx, value);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // wait for every outstanding verdict, then let the pipeline go quiet
   task automatic settle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (board.verdicts_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_limits(input int win, input int lim);
      settle();
      write_reg(CSR_WINDOW, win[CSR_DATA_W-1:0]);
      write_reg(CSR_MAX_HITS, {10'b0, lim[HITS_W-1:0]});
      settings++;
   endtask

   task automatic run_phase(input int n, input int win, input int lim, input int npool);
      logic [SLOT_IN_W-1:0] pool [4];
      logic [TIME_W-1:0]    at;
      logic [SLOT_IN_W-1:0] slot;
      int unsigned          span;
      int                   r;
      set_limits(win, lim);
      span = win / (2 * lim + 1) + 1;
      foreach (pool[k]) pool[k] = $urandom_range(0, SLOTS - 1);
      at = $urandom();
      repeat (n) begin
         if (npool > 4)
            slot = $urandom_range(0, SLOTS - 1);
         else
            slot = pool[$urandom_range(0, npool - 1)];
         r = $urandom_range(0, 99);
         if (r < 80)
            at += $urandom_range(0, span);
         else if (r < 90)
            at += win + $urandom_range(1, 1000);
         else if (r < 95)
            at -= $urandom_range(1, 100);
         else
            at = $urandom();
         send_request(slot, at);
      end
   endtask

   initial begin
      int win;
      int lim;
      int npool;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset limits: 60 second window, requests spaced just beyond it
      send_request(6'd1, 32'd0);
      send_request(6'd1, 32'd61);
      send_request(6'd1, 32'd121);

      // zero window, two hits: limit reached, then expiry of the whole log
      set_limits(0, 2);
      send_request(6'd0, 32'd100);
      send_request(6'd0, 32'd100);
      send_request(6'd0, 32'd100);
      send_request(6'd0, 32'd101);
      send_request(6'd0, 32'd101);
      // time going backwards across the top of the range
      send_request(6'd63, 32'hFFFF_FFFF);
      send_request(6'd63, 32'd0);
      send_request(6'd63, 32'd5);
      send_request(6'd42, 32'h5555_5555);
      send_request(6'd21, 32'hAAAA_AAAA);

      // zero limit refuses everything
      set_limits(65535, 0);
      send_request(6'd5, 32'd1000);
      send_request(6'd5, 32'hAAAA_AAAA);

      for (int p = 0; p < 14; p++) begin
         case (p % 4)
            0: win = 0;
            1: win = 65535;
            2: win = $urandom_range(1, 40);
            default: win = $urandom_range(0, 65535);
         endcase
         case (p % 5)
            0: lim = DEPTH;
            1: lim = 0;
            2: lim = 1;
            default: lim = $urandom_range(0, DEPTH);
         endcase
         npool = (p % 3 == 2) ? SLOTS : $urandom_range(1, 4);
         if (p == 13) begin
            settle();
            calm = 1'b1;
         end
         run_phase(100, win, lim, npool);
      end
      settle();
      board.finish_check();

      $display("%0d requests over %0d limit settings: %0d allowed, %0d refused",
               sent, settings, board.granted, board.denied);
      $display("%0d mismatches in %0d cycles", board.mismatches, cycle_count);
      if (board.mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
